// ===== rtl/sle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  localparam int DATA_W       = 32;
  localparam int OUT_CNT_W    = 5;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_POP    = 2'd2,
    ACT_ODD    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ODD,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_CAPTURE,
    OP_DELETE,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [OUT_CNT_W-1:0]     count;
    logic signed [DATA_W-1:0] smallest_value;
    logic                     list_empty;
  } rsp_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
    logic                     push;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sle_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sle_cell #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                              clk,
  input  sle_pkg::cell_cmd_t                cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]     count,
  input  logic [$clog2(CAPACITY)-1:0]       tail,
  input  logic signed [sle_pkg::DATA_W-1:0] left_data,
  input  logic                              left_less,
  input  logic signed [sle_pkg::DATA_W-1:0] right_data,
  output logic signed [sle_pkg::DATA_W-1:0] entry,
  output logic                              less,
  output logic                              hit
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic                     valid;
  logic                     below;
  logic signed [DATA_W-1:0] entry_next;

  assign valid = CW'(IDX) < count;
  assign less  = valid && (entry < cmd.value);

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      OP_HOLD:    entry_next = entry;
      OP_INSERT: begin
        // cells past the insert point move right, the insert point takes the value
        if (!left_less) entry_next = left_data;
        else if (!less) entry_next = cmd.value;
      end
      OP_CAPTURE: entry_next = entry;
      OP_DELETE: begin
        if (!below) entry_next = right_data;
      end
      OP_POP:     entry_next = right_data;
      OP_ROTATE: begin
        if (cmd.push && tail == IW'(IDX)) entry_next = cmd.value;
        else entry_next = right_data;
      end
      default:    entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (cmd.op == OP_CAPTURE) begin
      below <= less;
      hit   <= valid && (entry == cmd.value);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_engine_top.sv =====
// steps: insert and remove-smallest pass S_IDLE and S_FIN, remove-value S_IDLE, S_MATCH, S_FIN,
//   remove-odd S_IDLE, one S_ODD rotation step per stored entry, then S_FIN
// S_FIN waits for a free output register, and requests are taken only in S_IDLE;
//   a new request is taken while the previous response still waits in the output register
// reset: synchronous rst empties the list and drops any pending response; entry cells are
//   not cleared, only entries below the count are ever looked at
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_engine_top #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sle_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sle_pkg::rsp_t rsp_data
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  state_t    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW-1:0] len, len_next;
  status_t   status, status_next;
  cell_cmd_t cmd;
  logic [IW-1:0] tail;
  logic      accept;
  logic      load_rsp;
  logic      slot_free;
  logic      full;
  logic      found;
  logic      kept;
  action_t   action;

  logic signed [DATA_W-1:0] entry_vec [CAPACITY];
  logic signed [DATA_W-1:0] left_vec  [CAPACITY];
  logic signed [DATA_W-1:0] right_vec [CAPACITY];
  logic [CAPACITY-1:0]      less_vec;
  logic [CAPACITY-1:0]      left_less_vec;
  logic [CAPACITY-1:0]      hit_vec;
  logic signed [DATA_W-1:0] head;

  assign action    = action_t'(req_data.action);
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(CAPACITY));
  assign found     = |hit_vec;
  assign head      = entry_vec[0];
  // positive odd entries are dropped, negative odd ones stay
  assign kept      = !(head[0] && !head[DATA_W-1]);
  assign slot_free = !rsp_valid || rsp_ready;
  assign tail      = IW'(len - CW'(1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_vec[i]      = '0;
      assign left_less_vec[i] = 1'b1;
    end else begin : g_inner
      assign left_vec[i]      = entry_vec[i-1];
      assign left_less_vec[i] = less_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_vec[i] = '0;
    end else begin : g_body
      assign right_vec[i] = entry_vec[i+1];
    end

    sle_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .tail       (tail),
      .left_data  (left_vec[i]),
      .left_less  (left_less_vec[i]),
      .right_data (right_vec[i]),
      .entry      (entry_vec[i]),
      .less       (less_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_INSERT, ACT_POP: state_next = S_FIN;
            ACT_REMOVE:          state_next = S_MATCH;
            ACT_ODD:             state_next = S_ODD;
          endcase
        end
      end
      S_MATCH: state_next = S_FIN;
      S_ODD:   if (rem == '0) state_next = S_FIN;
      S_FIN:   if (slot_free) state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '{op: OP_HOLD, value: req_data.value, push: 1'b0};
    count_next  = count;
    rem_next    = rem;
    len_next    = len;
    status_next = status;
    load_rsp    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_INSERT: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                cmd.op      = OP_INSERT;
                count_next  = count + CW'(1);
                status_next = ST_OK;
              end
            end
            ACT_REMOVE: cmd.op = OP_CAPTURE;
            ACT_POP: begin
              if (count == '0) begin
                status_next = ST_MISS;
              end else begin
                cmd.op      = OP_POP;
                count_next  = count - CW'(1);
                status_next = ST_OK;
              end
            end
            ACT_ODD: begin
              rem_next    = count;
              len_next    = count;
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_MATCH: begin
        if (found) begin
          cmd.op      = OP_DELETE;
          count_next  = count - CW'(1);
          status_next = ST_OK;
        end else begin
          status_next = ST_MISS;
        end
      end
      S_ODD: begin
        if (rem != '0) begin
          // pop the head, append it behind the live part if it stays
          cmd.op    = OP_ROTATE;
          cmd.value = head;
          cmd.push  = kept;
          rem_next  = rem - CW'(1);
          if (!kept) len_next = len - CW'(1);
        end else begin
          count_next = len;
        end
      end
      S_FIN: load_rsp = slot_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    len    <= len_next;
    status <= status_next;
    if (load_rsp) begin
      rsp_data.status         <= status;
      rsp_data.count          <= OUT_CNT_W'(count);
      rsp_data.smallest_value <= (count != '0) ? head : '0;
      rsp_data.list_empty     <= (count == '0);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && action == ACT_INSERT && !full |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_rotate_len: assert property (@(posedge clk) disable iff (rst)
    state == S_ODD |-> (len >= rem) && (len <= count))
    else $error("rotation length out of range");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.list_empty |-> rsp_data.smallest_value == '0 && rsp_data.count == '0)
    else $error("empty response carries a head value");
`endif

endmodule

`default_nettype wire
